// ===== hw/rtl/dnsa_pkg.sv =====
// Package for the DNS reply A-record extractor.
// Holds the parse phase type, status codes, protocol constants and the result struct.
// No dependencies.
`default_nettype none

package dnsa_pkg;

   // Parse phases of the reply walker.
   typedef enum logic [3:0] {
      PH_HEADER = 4'd0,
      PH_QNAME  = 4'd1,
      PH_QLABEL = 4'd2,
      PH_QTAIL  = 4'd3,
      PH_ANAME  = 4'd4,
      PH_ALABEL = 4'd5,
      PH_APTR   = 4'd6,
      PH_AFIXED = 4'd7,
      PH_AADDR  = 4'd8,
      PH_ASKIP  = 4'd9,
      PH_DONE   = 4'd10
   } phase_type;

   // Result status codes.
   localparam logic [1:0] STATUS_FOUND      = 2'd0;
   localparam logic [1:0] STATUS_IGNORED    = 2'd1;
   localparam logic [1:0] STATUS_SERVER_ERR = 2'd2;
   localparam logic [1:0] STATUS_NO_A       = 2'd3;

   // DNS framing constants.
   localparam int unsigned HEADER_BYTES   = 12;
   localparam int unsigned POS_ID_HIGH    = 0;
   localparam int unsigned POS_ID_LOW     = 1;
   localparam int unsigned POS_RCODE      = 3;
   localparam int unsigned POS_ANCOUNT_HI = 6;
   localparam int unsigned POS_ANCOUNT_LO = 7;
   localparam int unsigned POS_HEADER_END = 11;

   localparam logic [7:0]  POINTER_MASK   = 8'd192;
   localparam logic [3:0]  RCODE_NONE     = 4'd0;
   localparam logic [15:0] QTAIL_BYTES    = 16'd4;
   localparam logic [15:0] QPTR_SKIP      = 16'd5;
   localparam logic [15:0] APTR_SKIP      = 16'd1;
   localparam logic [15:0] FIXED_TYPECLS  = 16'd3;
   localparam logic [15:0] FIXED_RDLEN    = 16'd9;
   localparam logic [15:0] ADDR_BYTES     = 16'd4;
   localparam logic [31:0] TYPE_A_CLASS_IN = 32'h0001_0001;

   // One result item.
   typedef struct packed {
      logic [3:0]  response_code;
      logic [31:0] ipv4_address;
      logic [1:0]  status;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dns_reply_a_record_extract_top.sv =====
// Top level of the DNS reply A-record extractor.
// Depends on dnsa_pkg, dnsa_parser and dnsa_out_reg.
`default_nettype none

// The block takes one reply byte per cycle on the req_ stream, with tlast on the
// final byte of each datagram, and gives one result item on the rsp_ stream per
// datagram, registered after its final byte is accepted. Every byte updates the
// parser state in the cycle it is accepted, so the sustained rate is one item per
// cycle. Bytes that do not end a datagram are always accepted; a final byte waits
// only while the previous result item is still held in the result register and
// not being taken. Bytes past MAX_REPLY_BYTES are dropped but their tlast still
// closes the datagram. The expected transaction id is written on the csr_ channel,
// which is always ready and should be written between datagrams.
module dns_reply_a_record_extract_top #(
   parameter int unsigned MAX_REPLY_BYTES = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration: expected_id.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data,
   // Input items. tdata: [7:0] reply_byte. tlast: last_byte.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   // Result items. tdata: [1:0] status, [33:2] ipv4_address,
   // [37:34] response_code, [39:38] zero.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata
);

   logic [15:0] expected_id_ff;
   logic        take;
   logic        load;
   dnsa_pkg::result_type result;
   dnsa_pkg::result_type rsp_data;

   // Configuration register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= 16'd0;
      end else if (csr_valid) begin
         expected_id_ff <= csr_data;
      end
   end

   // A final byte needs room in the result register; other bytes never wait.
   assign req_tready = ~(rsp_tvalid & ~rsp_tready & req_tlast);
   assign take       = req_tvalid & req_tready;
   assign load       = take & req_tlast;

   dnsa_parser #(
      .MAX_REPLY_BYTES(MAX_REPLY_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .reply_byte  (req_tdata),
      .last_byte   (req_tlast),
      .expected_id (expected_id_ff),
      .result      (result)
   );

   dnsa_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .result    (result),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_data)
   );

   // Pack the result item fields, lowest first.
   assign rsp_tdata = {2'b00, rsp_data.response_code, rsp_data.ipv4_address, rsp_data.status};

endmodule

`default_nettype wire

// ===== hw/rtl/dnsa_parser.sv =====
// Byte-serial DNS reply parser: per-item state update and result formation.
// Depends on dnsa_pkg.
`default_nettype none

module dnsa_parser #(
   parameter int unsigned MAX_REPLY_BYTES = 512
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire logic [7:0]            reply_byte,
   input  wire logic                  last_byte,
   input  wire logic [15:0]           expected_id,
   output dnsa_pkg::result_type       result
);

   localparam int unsigned PW = $clog2(MAX_REPLY_BYTES + 1);
   localparam logic [PW-1:0] LIMIT = PW'(MAX_REPLY_BYTES);

   dnsa_pkg::phase_type phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [15:0]   answers_ff, answers_in;
   logic [15:0]   skip_ff, skip_in;
   logic [23:0]   field_ff, field_in;
   logic          isa_ff, isa_in;
   logic [31:0]   addr_ff, addr_in;
   logic [1:0]    outcome_ff, outcome_in;
   logic [3:0]    rcode_ff, rcode_in;

   // Next state for one accepted byte, then the result, then the clear on the final byte.
   always_comb begin
      logic        q;
      logic [15:0] id;
      logic [31:0] fs;
      logic [15:0] rdl;
      logic [15:0] skip_dec;
      logic [1:0]  st;
      q          = (phase_ff == dnsa_pkg::PH_QNAME);
      id         = {field_ff[7:0], reply_byte};
      fs         = {field_ff, reply_byte};
      rdl        = fs[15:0];
      skip_dec   = skip_ff - 16'd1;
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      answers_in = answers_ff;
      skip_in    = skip_ff;
      field_in   = field_ff;
      isa_in     = isa_ff;
      addr_in    = addr_ff;
      outcome_in = outcome_ff;
      rcode_in   = rcode_ff;

      if (take && (pos_ff < LIMIT)) begin
         pos_in = pos_ff + PW'(1);
         case (phase_ff)
            dnsa_pkg::PH_HEADER: begin
               if (pos_ff == PW'(dnsa_pkg::POS_ID_HIGH)) begin
                  field_in = {16'd0, reply_byte};
               end else if (pos_ff == PW'(dnsa_pkg::POS_ID_LOW)) begin
                  field_in   = {8'd0, id};
                  outcome_in = (id == expected_id) ? dnsa_pkg::STATUS_NO_A
                                                   : dnsa_pkg::STATUS_IGNORED;
               end else if (pos_ff == PW'(dnsa_pkg::POS_RCODE)) begin
                  rcode_in = reply_byte[3:0];
                  if ((reply_byte[3:0] != dnsa_pkg::RCODE_NONE) &&
                      (outcome_ff == dnsa_pkg::STATUS_NO_A)) begin
                     outcome_in = dnsa_pkg::STATUS_SERVER_ERR;
                  end
               end else if ((pos_ff == PW'(dnsa_pkg::POS_ANCOUNT_HI)) ||
                            (pos_ff == PW'(dnsa_pkg::POS_ANCOUNT_LO))) begin
                  answers_in = {answers_ff[7:0], reply_byte};
               end else if (pos_ff == PW'(dnsa_pkg::POS_HEADER_END)) begin
                  phase_in = (outcome_ff == dnsa_pkg::STATUS_NO_A) ? dnsa_pkg::PH_QNAME
                                                                   : dnsa_pkg::PH_DONE;
               end
            end
            dnsa_pkg::PH_QNAME, dnsa_pkg::PH_ANAME: begin
               if (reply_byte == 8'd0) begin
                  field_in = 24'd0;
                  skip_in  = q ? dnsa_pkg::QTAIL_BYTES : 16'd0;
                  phase_in = q ? dnsa_pkg::PH_QTAIL : dnsa_pkg::PH_AFIXED;
               end else if ((reply_byte & dnsa_pkg::POINTER_MASK) == dnsa_pkg::POINTER_MASK) begin
                  // A compression pointer ends the name after its second byte.
                  field_in = 24'd0;
                  skip_in  = q ? dnsa_pkg::QPTR_SKIP : dnsa_pkg::APTR_SKIP;
                  phase_in = q ? dnsa_pkg::PH_QTAIL : dnsa_pkg::PH_APTR;
               end else begin
                  skip_in  = {8'd0, reply_byte};
                  phase_in = q ? dnsa_pkg::PH_QLABEL : dnsa_pkg::PH_ALABEL;
               end
            end
            dnsa_pkg::PH_QLABEL, dnsa_pkg::PH_ALABEL: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  phase_in = (phase_ff == dnsa_pkg::PH_QLABEL) ? dnsa_pkg::PH_QNAME
                                                               : dnsa_pkg::PH_ANAME;
               end
            end
            dnsa_pkg::PH_QTAIL, dnsa_pkg::PH_ASKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  if (answers_ff == 16'd0) begin
                     phase_in = dnsa_pkg::PH_DONE;
                  end else begin
                     answers_in = answers_ff - 16'd1;
                     phase_in   = dnsa_pkg::PH_ANAME;
                  end
               end
            end
            dnsa_pkg::PH_APTR: begin
               skip_in  = 16'd0;
               field_in = 24'd0;
               phase_in = dnsa_pkg::PH_AFIXED;
            end
            dnsa_pkg::PH_AFIXED: begin
               // Type, class, TTL and data length arrive as ten bytes.
               field_in = fs[23:0];
               if (skip_ff == dnsa_pkg::FIXED_TYPECLS) begin
                  isa_in = (fs == dnsa_pkg::TYPE_A_CLASS_IN);
               end
               if (skip_ff == dnsa_pkg::FIXED_RDLEN) begin
                  if (isa_ff && (rdl == dnsa_pkg::ADDR_BYTES)) begin
                     addr_in  = 32'd0;
                     skip_in  = dnsa_pkg::ADDR_BYTES;
                     phase_in = dnsa_pkg::PH_AADDR;
                  end else if (rdl == 16'd0) begin
                     if (answers_ff == 16'd0) begin
                        phase_in = dnsa_pkg::PH_DONE;
                     end else begin
                        answers_in = answers_ff - 16'd1;
                        phase_in   = dnsa_pkg::PH_ANAME;
                     end
                  end else begin
                     skip_in  = rdl;
                     phase_in = dnsa_pkg::PH_ASKIP;
                  end
               end else begin
                  skip_in = skip_ff + 16'd1;
               end
            end
            dnsa_pkg::PH_AADDR: begin
               addr_in = {addr_ff[23:0], reply_byte};
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  outcome_in = dnsa_pkg::STATUS_FOUND;
                  phase_in   = dnsa_pkg::PH_DONE;
               end
            end
            default: begin
               phase_in = dnsa_pkg::PH_DONE;
            end
         endcase
      end

      // Result of the datagram, taken from the state after this byte.
      st = (pos_in < PW'(dnsa_pkg::HEADER_BYTES)) ? dnsa_pkg::STATUS_IGNORED : outcome_in;
      result.status        = st;
      result.ipv4_address  = (st == dnsa_pkg::STATUS_FOUND) ? addr_in : 32'd0;
      result.response_code = rcode_in;

      // The final byte returns the parser to its idle state.
      if (take && last_byte) begin
         phase_in   = dnsa_pkg::PH_HEADER;
         pos_in     = '0;
         answers_in = 16'd0;
         skip_in    = 16'd0;
         field_in   = 24'd0;
         isa_in     = 1'b0;
         addr_in    = 32'd0;
         outcome_in = dnsa_pkg::STATUS_FOUND;
         rcode_in   = 4'd0;
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= dnsa_pkg::PH_HEADER;
         pos_ff     <= '0;
         answers_ff <= 16'd0;
         skip_ff    <= 16'd0;
         field_ff   <= 24'd0;
         isa_ff     <= 1'b0;
         addr_ff    <= 32'd0;
         outcome_ff <= dnsa_pkg::STATUS_FOUND;
         rcode_ff   <= 4'd0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         answers_ff <= answers_in;
         skip_ff    <= skip_in;
         field_ff   <= field_in;
         isa_ff     <= isa_in;
         addr_ff    <= addr_in;
         outcome_ff <= outcome_in;
         rcode_ff   <= rcode_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dnsa_out_reg.sv =====
// Result register for the DNS reply extractor: holds one result item until taken.
// Depends on dnsa_pkg.
`default_nettype none

module dnsa_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire dnsa_pkg::result_type  result,
   input  wire logic                  out_ready,
   output logic                       out_valid,
   output dnsa_pkg::result_type       out_data
);

   logic                 valid_ff, valid_in;
   dnsa_pkg::result_type data_ff;

   // A loaded item stays until the consumer takes it.
   always_comb begin
      valid_in = load | (valid_ff & ~out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dnsa_checker.sv =====
// Port-level assertions for the DNS reply A-record extractor, bound to the top level.
// Depends on dns_reply_a_record_extract_top.
`default_nettype none

module dnsa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   // A stalled result item holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result item changed while stalled");

   // The address is zero unless an address was found.
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] != 2'd0)) |-> (rsp_tdata[33:2] == 32'd0))
      else $error("address present with a failure status");

   // A new result item follows only the acceptance of a final byte.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast))
      else $error("result item without a final byte");

   // A final byte is never refused while the result register is free.
   a_last_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid && req_tvalid && req_tlast) |-> req_tready)
      else $error("final byte refused with an empty result register");

endmodule

bind dns_reply_a_record_extract_top dnsa_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for dns_reply_a_record_extract_top: directed replies, then random ones.
// Each accepted byte goes through a bit-true parser model here and results are checked in order.
// Depends on dnsa_pkg and the RTL of the extractor.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned REPLY_LIMIT    = 512;
   localparam int unsigned PHASE_BYTES    = 420;
   localparam int unsigned LONG_HOLD      = 400;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned QUEUE_DEPTH    = 32;

   // One input item, with an optional expectation typed in by hand.
   typedef struct packed {
      logic [7:0]           data;
      logic                 last;
      logic                 typed;
      dnsa_pkg::result_type want;
   } reply_item_type;

   typedef enum logic [1:0] {RX_STEADY, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   // Directed replies: a lone byte, a header with an error code, a header with a foreign id.
   localparam reply_item_type DIRECTED_REPLIES [25] = '{
      '{8'hFF, 1'b1, 1'b1, '{4'd0, 32'd0, dnsa_pkg::STATUS_IGNORED}},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h81, 1'b0, 1'b0, '0},
      '{8'h8F, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{4'd15, 32'd0, dnsa_pkg::STATUS_SERVER_ERR}},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h85, 1'b0, 1'b0, '0},
      '{8'h83, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b1, 1'b1, '{4'd3, 32'd0, dnsa_pkg::STATUS_IGNORED}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   // Parser model state.
   dnsa_pkg::phase_type wk_phase;
   logic [9:0]  wk_pos;
   logic [15:0] wk_answers;
   logic [15:0] wk_skip;
   logic [31:0] wk_shift;
   logic        wk_is_a;
   logic [31:0] wk_addr;
   logic [1:0]  wk_outcome;
   logic [3:0]  wk_rcode;
   logic [15:0] wk_expected_id;

   reply_item_type       send_q[$];
   dnsa_pkg::result_type expected_results[$];
   logic [7:0]           reply_body[$];

   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned hold_requests = 0;
   int unsigned idle_cycles = 0;

   dns_reply_a_record_extract_top #(
      .MAX_REPLY_BYTES(REPLY_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Return the parser to its idle state between datagrams.
   function automatic void clear_walk();
      wk_phase   = dnsa_pkg::PH_HEADER;
      wk_pos     = '0;
      wk_answers = '0;
      wk_skip    = '0;
      wk_shift   = '0;
      wk_is_a    = 1'b0;
      wk_addr    = '0;
      wk_outcome = dnsa_pkg::STATUS_FOUND;
      wk_rcode   = dnsa_pkg::RCODE_NONE;
   endfunction

   // Move on to the next answer record, or stop when the count is used up.
   function automatic void next_answer();
      if (wk_answers == 16'd0) begin
         wk_phase = dnsa_pkg::PH_DONE;
      end else begin
         wk_answers = wk_answers - 16'd1;
         wk_phase = dnsa_pkg::PH_ANAME;
      end
   endfunction

   // Feed one reply byte to the model; returns 1 with the result on the final byte.
   function automatic bit extract_step(input logic [7:0] b, input logic last,
                                       output dnsa_pkg::result_type res);
      logic        in_question;
      logic [15:0] rdlen;
      res = '0;
      in_question = (wk_phase == dnsa_pkg::PH_QNAME);
      if (wk_pos < REPLY_LIMIT) begin
         case (wk_phase)
            dnsa_pkg::PH_HEADER: begin
               if (wk_pos == dnsa_pkg::POS_ID_HIGH) begin
                  wk_shift = {24'd0, b};
               end else if (wk_pos == dnsa_pkg::POS_ID_LOW) begin
                  wk_shift = {16'd0, wk_shift[7:0], b};
                  wk_outcome = (wk_shift[15:0] == wk_expected_id) ? dnsa_pkg::STATUS_NO_A
                                                                  : dnsa_pkg::STATUS_IGNORED;
               end else if (wk_pos == dnsa_pkg::POS_RCODE) begin
                  wk_rcode = b[3:0];
                  if (wk_rcode != dnsa_pkg::RCODE_NONE && wk_outcome == dnsa_pkg::STATUS_NO_A)
                     wk_outcome = dnsa_pkg::STATUS_SERVER_ERR;
               end else if (wk_pos == dnsa_pkg::POS_ANCOUNT_HI ||
                            wk_pos == dnsa_pkg::POS_ANCOUNT_LO) begin
                  wk_answers = {wk_answers[7:0], b};
               end else if (wk_pos == dnsa_pkg::POS_HEADER_END) begin
                  wk_phase = (wk_outcome == dnsa_pkg::STATUS_NO_A) ? dnsa_pkg::PH_QNAME
                                                                   : dnsa_pkg::PH_DONE;
               end
            end
            dnsa_pkg::PH_QNAME, dnsa_pkg::PH_ANAME: begin
               // A zero ends the name, two top bits mark a pointer, anything else is a label.
               if (b == 8'd0) begin
                  wk_shift = '0;
                  wk_skip  = in_question ? dnsa_pkg::QTAIL_BYTES : 16'd0;
                  wk_phase = in_question ? dnsa_pkg::PH_QTAIL : dnsa_pkg::PH_AFIXED;
               end else if ((b & dnsa_pkg::POINTER_MASK) == dnsa_pkg::POINTER_MASK) begin
                  wk_shift = '0;
                  wk_skip  = in_question ? dnsa_pkg::QPTR_SKIP : dnsa_pkg::APTR_SKIP;
                  wk_phase = in_question ? dnsa_pkg::PH_QTAIL : dnsa_pkg::PH_APTR;
               end else begin
                  wk_skip  = {8'd0, b};
                  wk_phase = in_question ? dnsa_pkg::PH_QLABEL : dnsa_pkg::PH_ALABEL;
               end
            end
            dnsa_pkg::PH_QLABEL, dnsa_pkg::PH_ALABEL: begin
               wk_skip = wk_skip - 16'd1;
               if (wk_skip == 16'd0)
                  wk_phase = (wk_phase == dnsa_pkg::PH_QLABEL) ? dnsa_pkg::PH_QNAME
                                                               : dnsa_pkg::PH_ANAME;
            end
            dnsa_pkg::PH_QTAIL, dnsa_pkg::PH_ASKIP: begin
               wk_skip = wk_skip - 16'd1;
               if (wk_skip == 16'd0)
                  next_answer();
            end
            dnsa_pkg::PH_APTR: begin
               wk_skip  = '0;
               wk_shift = '0;
               wk_phase = dnsa_pkg::PH_AFIXED;
            end
            dnsa_pkg::PH_AFIXED: begin
               // Type, class, TTL and data length; the count runs up through the ten bytes.
               wk_shift = {wk_shift[23:0], b};
               if (wk_skip == dnsa_pkg::FIXED_TYPECLS)
                  wk_is_a = (wk_shift == dnsa_pkg::TYPE_A_CLASS_IN);
               if (wk_skip == dnsa_pkg::FIXED_RDLEN) begin
                  rdlen = wk_shift[15:0];
                  if (wk_is_a && rdlen == dnsa_pkg::ADDR_BYTES) begin
                     wk_addr  = '0;
                     wk_skip  = dnsa_pkg::ADDR_BYTES;
                     wk_phase = dnsa_pkg::PH_AADDR;
                  end else if (rdlen == 16'd0) begin
                     next_answer();
                  end else begin
                     wk_skip  = rdlen;
                     wk_phase = dnsa_pkg::PH_ASKIP;
                  end
               end else begin
                  wk_skip = wk_skip + 16'd1;
               end
            end
            dnsa_pkg::PH_AADDR: begin
               wk_addr = {wk_addr[23:0], b};
               wk_skip = wk_skip - 16'd1;
               if (wk_skip == 16'd0) begin
                  wk_outcome = dnsa_pkg::STATUS_FOUND;
                  wk_phase = dnsa_pkg::PH_DONE;
               end
            end
            default: wk_phase = dnsa_pkg::PH_DONE;
         endcase
         wk_pos = wk_pos + 10'd1;
      end
      if (!last)
         return 1'b0;
      res.status = (wk_pos < dnsa_pkg::HEADER_BYTES) ? dnsa_pkg::STATUS_IGNORED : wk_outcome;
      res.ipv4_address = (res.status == dnsa_pkg::STATUS_FOUND) ? wk_addr : 32'd0;
      res.response_code = wk_rcode;
      clear_walk();
      return 1'b1;
   endfunction

   // Append one label with random content; a few use lengths with a single top bit set.
   function automatic void add_label();
      int unsigned pick;
      int unsigned len;
      pick = $urandom_range(0, 39);
      if (pick < 2)
         len = $urandom_range(64, 70);
      else if (pick == 2)
         len = $urandom_range(128, 134);
      else if (pick == 3)
         len = $urandom_range(180, 191);
      else
         len = $urandom_range(1, 6);
      reply_body.push_back(8'(len));
      repeat (len) reply_body.push_back(8'($urandom));
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want_v,
                                  input logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: result %0d, %s: expected 0x%0h, got 0x%0h",
                  $time, results_seen, field, want_v, got_v);
   endtask

   // Wait until nothing is queued, offered or expected.
   task automatic wait_idle();
      do @(negedge clock);
      while (send_q.size() != 0 || req_tvalid || expected_results.size() != 0);
   endtask

   // Write the expected transaction id while the block is idle.
   task automatic program_id(input logic [15:0] id);
      wait_idle();
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= id;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      wk_expected_id = id;
   endtask

   // Hand the bytes of reply_body to the sender, the last one flagged.
   task automatic queue_reply();
      reply_item_type it;
      do @(negedge clock);
      while (send_q.size() > QUEUE_DEPTH);
      foreach (reply_body[i]) begin
         it = '0;
         it.data = reply_body[i];
         it.last = (i == reply_body.size() - 1);
         send_q.push_back(it);
      end
   endtask

   // One id setting followed by random replies, mostly well formed.
   task automatic run_phase(input logic [15:0] id, input bit long_hold, input bit long_reply);
      int unsigned sent;
      int unsigned pick;
      int unsigned ancount;
      int unsigned n_rec;
      int unsigned rdlen;
      int unsigned target;
      logic [15:0] hdr_id;
      logic [7:0]  flags;
      logic [31:0] type_class;
      bit          first_reply;
      sent = 0;
      first_reply = 1'b1;
      program_id(id);
      // Stall the receiver and pile up one-byte replies so the input backs up.
      if (long_hold) begin
         hold_requests++;
         repeat (8) begin
            reply_body.delete();
            reply_body.push_back(8'($urandom));
            queue_reply();
         end
      end
      while (sent < PHASE_BYTES) begin
         reply_body.delete();
         if (!(long_reply && first_reply) && $urandom_range(0, 9) == 0) begin
            // Noise: random bytes of random length.
            repeat ($urandom_range(1, 40)) reply_body.push_back(8'($urandom));
         end else begin
            // Header.
            hdr_id = ($urandom_range(0, 9) != 0) ? id : 16'($urandom);
            reply_body.push_back(hdr_id[15:8]);
            reply_body.push_back(hdr_id[7:0]);
            reply_body.push_back(8'($urandom));
            flags = 8'($urandom);
            if ($urandom_range(0, 4) != 0)
               flags[3:0] = dnsa_pkg::RCODE_NONE;
            reply_body.push_back(flags);
            repeat (2) reply_body.push_back(8'($urandom));
            ancount = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 2);
            reply_body.push_back(8'(ancount >> 8));
            reply_body.push_back(8'(ancount));
            repeat (4) reply_body.push_back(8'($urandom));
            // Question name and its type and class.
            if ($urandom_range(0, 3) == 0) begin
               reply_body.push_back({2'b11, 6'($urandom)});
               reply_body.push_back(8'($urandom));
            end else begin
               repeat ($urandom_range(0, 2)) add_label();
               reply_body.push_back(8'd0);
            end
            repeat (4) reply_body.push_back(8'($urandom));
            // Answer records.
            n_rec = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                                                : ((ancount > 3) ? 3 : ancount);
            repeat (n_rec) begin
               pick = $urandom_range(0, 9);
               if (pick < 4) begin
                  reply_body.push_back({2'b11, 6'($urandom)});
                  reply_body.push_back(8'($urandom));
               end else if (pick < 7) begin
                  reply_body.push_back(8'd0);
               end else begin
                  repeat ($urandom_range(1, 2)) add_label();
                  reply_body.push_back(8'd0);
               end
               pick = $urandom_range(0, 9);
               if (pick < 6)
                  type_class = dnsa_pkg::TYPE_A_CLASS_IN;
               else if (pick < 8)
                  type_class = dnsa_pkg::TYPE_A_CLASS_IN ^ (32'd1 << $urandom_range(0, 31));
               else
                  type_class = $urandom;
               for (int k = 3; k >= 0; k--)
                  reply_body.push_back(type_class[8*k +: 8]);
               repeat (4) reply_body.push_back(8'($urandom));
               if (type_class == dnsa_pkg::TYPE_A_CLASS_IN && $urandom_range(0, 9) < 8)
                  rdlen = 4;
               else if ($urandom_range(0, 29) == 0)
                  rdlen = $urandom_range(0, 65535);
               else
                  rdlen = $urandom_range(0, 8);
               reply_body.push_back(8'(rdlen >> 8));
               reply_body.push_back(8'(rdlen));
               repeat ((rdlen > 10) ? 10 : rdlen) reply_body.push_back(8'($urandom));
            end
            // Cut some replies short and give others trailing bytes.
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
               target = $urandom_range(1, reply_body.size());
               while (reply_body.size() > target) void'(reply_body.pop_back());
            end else if (pick == 2) begin
               repeat ($urandom_range(1, 6)) reply_body.push_back(8'($urandom));
            end
         end
         // One reply is padded to at least a random target of 505 to 560 bytes, so it often runs past the size limit.
         if (long_reply && first_reply) begin
            target = $urandom_range(505, 560);
            while (reply_body.size() < target) reply_body.push_back(8'($urandom));
         end
         first_reply = 1'b0;
         sent += reply_body.size();
         queue_reply();
      end
   endtask

   // Sender: offers queued bytes in bursts with random gaps and runs the model on acceptance.
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   always @(posedge clock) begin
      dnsa_pkg::result_type predicted;
      bit                   produced;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            produced = extract_step(send_q[0].data, send_q[0].last, predicted);
            if (produced)
               expected_results.push_back(send_q[0].typed ? send_q[0].want : predicted);
            void'(send_q.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            // Item still offered; hold it.
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (send_q.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= send_q[0].data;
            req_tlast  <= send_q[0].last;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 300)
                                                        : $urandom_range(1, 40);
               gap_left = $urandom_range(1, 12);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: ready pattern that changes mode now and then, plus long holds on request.
   rx_mode_type rx_mode = RX_STEADY;
   int unsigned rx_mode_left = 0;
   int unsigned holds_done = 0;
   int unsigned hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_left == 0 && holds_done != hold_requests) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         if (rx_mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 200);
         end else begin
            rx_mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_STEADY: rsp_tready <= 1'b1;
               RX_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 4) == 0);
               default:   rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      dnsa_pkg::result_type got;
      dnsa_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[37:0];
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, status", 32'd0, 32'(got.status));
         end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(got.status));
            if (got.ipv4_address !== want.ipv4_address)
               report_mismatch("ipv4_address", want.ipv4_address, got.ipv4_address);
            if (got.response_code !== want.response_code)
               report_mismatch("response_code", 32'(want.response_code),
                               32'(got.response_code));
         end
      end
   end

   // Watchdog: too long without any item moving on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("dns_reply_a_record_extract_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main sequence: reset, directed table, then four id settings with random replies.
   initial begin
      logic [15:0] phase_id;
      clear_walk();
      wk_expected_id = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      program_id(16'h0000);
      @(negedge clock);
      foreach (DIRECTED_REPLIES[i]) send_q.push_back(DIRECTED_REPLIES[i]);

      for (int p = 0; p < 4; p++) begin
         phase_id = (p == 0) ? 16'hFFFF : 16'($urandom);
         run_phase(phase_id, p == 1, p == 2);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("dns_reply_a_record_extract_top: match");
      else
         $display("dns_reply_a_record_extract_top: mismatch");
      $finish;
   end

endmodule
